// ===== rtl/point_in_polygon_test_assert.svh =====
// Assertion macros for the point-in-polygon test block.
`ifndef POINT_IN_POLYGON_TEST_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_ASSERT_SVH

`ifndef SYNTH
`define PIP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PIP_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define PIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/pip_pkg.sv =====
// Shared constants and controller/datapath link types for the point-in-polygon test.
package pip_pkg;

    localparam int VIDX_WIDTH   = 6;
    localparam int VCOUNT_WIDTH = 7;

    localparam logic [VCOUNT_WIDTH-1:0] VCOUNT_RESET = 7'd3;
    localparam logic [VCOUNT_WIDTH-1:0] VCOUNT_MIN   = 7'd3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TEST = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic first;
        logic close;
        logic capture;
        logic clear;
        logic load_out;
    } t_pip_cmd;

    typedef struct packed {
        logic busy;
        logic out_full;
    } t_pip_sts;

endpackage

// ===== rtl/pip_ifs.sv =====
// Valid/ready channel interfaces: point/vertex input beats and result beats.
interface pip_pt_if #(
    parameter int COORD_WIDTH = 16
);
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [pip_pkg::VIDX_WIDTH-1:0]     vertex_index;
    logic signed [COORD_WIDTH-1:0]      x_coord;
    logic signed [COORD_WIDTH-1:0]      y_coord;

    modport source (output valid, output mode, output vertex_index, output x_coord,
                    output y_coord, input ready);
    modport sink   (input valid, input mode, input vertex_index, input x_coord,
                    input y_coord, output ready);
endinterface

interface pip_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, output inside_res, input ready);
    modport sink   (input valid, input inside_res, output ready);
endinterface

// ===== rtl/point_in_polygon_test.sv =====
// Point-in-polygon test top level: ray-casting parity over a stored polygon.
// Load beat: writes one vertex slot. Test beat: the walk makes n store reads, n = clamped
// vertex count, one store read per cycle, then the closing edge; the edge pipeline drains.
// Next beat is taken once the test hands its result to the output register; the hand-off
// waits while that register is still full. Reset clears control, the pipeline, the parity and the result valid flag;
// vertex_count goes to 3. Vertex store is not cleared: contents undefined until loaded.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pip_pt_if.sink                            i_pt,
    pip_res_if.source                         o_res,
    input  logic                              i_cfg_we,
    input  logic [pip_pkg::VCOUNT_WIDTH-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(MAX_VERTICES);

    pip_pkg::t_pip_cmd  w_cmd;
    pip_pkg::t_pip_sts  w_sts;
    logic [AW-1:0]      w_rd_addr;
    logic               w_in_ready;
    logic               w_test_accept;

    assign i_pt.ready    = w_in_ready;
    assign w_test_accept = i_pt.valid && w_in_ready && (i_pt.mode == pip_pkg::MODE_TEST);

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pt.valid),
        .i_in_mode   (i_pt.mode),
        .o_in_ready  (w_in_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_rd_addr      (w_rd_addr),
        .o_sts          (w_sts),
        .i_vertex_index (i_pt.vertex_index),
        .i_x_coord      (i_pt.x_coord),
        .i_y_coord      (i_pt.y_coord),
        .o_res_valid    (o_res.valid),
        .i_res_ready    (o_res.ready),
        .o_inside_res   (o_res.inside_res)
    );

`include "point_in_polygon_test_assert.svh"

    // no beat taken while edges are still in flight
`PIP_ASSERT_IMPLIES(a_busy_blocks_input, i_clk, i_rst_n, w_sts.busy, !w_in_ready)
    // result register never overwritten
`PIP_ASSERT_IMPLIES(a_no_result_overwrite, i_clk, i_rst_n, w_cmd.load_out, !w_sts.out_full)
    // accepted test starts its walk at vertex 0
`PIP_ASSERT_NEXT(a_test_starts_walk, i_clk, i_rst_n, w_test_accept, w_cmd.rd_en && w_cmd.first)

endmodule

// ===== rtl/pip_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pip_ctrl.sv =====
// Sequencer: accepts beats, walks the vertex store, hands the parity to the output.
module pip_ctrl #(
    parameter int MAX_VERTICES = 64,
    localparam int AW = $clog2(MAX_VERTICES)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_mode,
    output logic                                o_in_ready,
    input  logic                                i_cfg_we,
    input  logic [pip_pkg::VCOUNT_WIDTH-1:0]    i_cfg_wdata,
    input  pip_pkg::t_pip_sts                   i_sts,
    output pip_pkg::t_pip_cmd                   o_cmd,
    output logic [AW-1:0]                       o_rd_addr
);

    localparam int CNTW = (AW > pip_pkg::VCOUNT_WIDTH) ? AW : pip_pkg::VCOUNT_WIDTH;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CLOSE,
        ST_DRAIN
    } t_state;

    t_state                             r_state;
    logic [AW-1:0]                      r_cnt;
    logic [pip_pkg::VCOUNT_WIDTH-1:0]   r_vertex_count;
    logic [pip_pkg::VCOUNT_WIDTH-1:0]   w_last;
    logic                               w_at_last;
    logic                               w_accept;

    // clamp count to [3, MAX_VERTICES], then index of last vertex
    always_comb begin
        if (r_vertex_count < pip_pkg::VCOUNT_MIN) begin
            w_last = pip_pkg::VCOUNT_MIN - 7'd1;
        end else if (32'(r_vertex_count) > MAX_VERTICES) begin
            w_last = pip_pkg::VCOUNT_WIDTH'(MAX_VERTICES - 1);
        end else begin
            w_last = r_vertex_count - 7'd1;
        end
    end

    assign w_at_last  = (CNTW'(r_cnt) == CNTW'(w_last));
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_rd_addr  = r_cnt;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_mode == pip_pkg::MODE_LOAD) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        o_cmd.clear   = 1'b1;
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.first = (r_cnt == '0);
            end
            ST_CLOSE: begin
                o_cmd.close = 1'b1;
            end
            ST_DRAIN: begin
                o_cmd.load_out = !i_sts.busy && !i_sts.out_full;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_cnt          <= '0;
            r_vertex_count <= pip_pkg::VCOUNT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_vertex_count <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (w_accept && (i_in_mode == pip_pkg::MODE_TEST)) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (w_at_last) begin
                        r_state <= ST_CLOSE;
                    end else begin
                        r_cnt <= r_cnt + AW'(1);
                    end
                end
                ST_CLOSE: begin
                    r_state <= ST_DRAIN;
                end
                ST_DRAIN: begin
                    if (!i_sts.busy && !i_sts.out_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/pip_dp.sv =====
// Datapath: vertex store, edge pipeline with exact crossing compare, parity and result register.
module pip_dp #(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_WIDTH  = 16,
    localparam int AW = $clog2(MAX_VERTICES)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pip_pkg::t_pip_cmd                 i_cmd,
    input  logic [AW-1:0]                     i_rd_addr,
    output pip_pkg::t_pip_sts                 o_sts,
    input  logic [pip_pkg::VIDX_WIDTH-1:0]    i_vertex_index,
    input  logic signed [COORD_WIDTH-1:0]     i_x_coord,
    input  logic signed [COORD_WIDTH-1:0]     i_y_coord,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic                              o_inside_res
);

    localparam int CW = COORD_WIDTH;
    localparam int VW = 2 * CW;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;

    logic                   w_wr_en;
    logic [VW-1:0]          w_rdata;
    logic [VW-1:0]          w_cur;

    logic signed [CW-1:0]   r_px;
    logic signed [CW-1:0]   r_py;
    logic [VW-1:0]          r_v0;
    logic [VW-1:0]          r_prev;

    logic                   r_s0_vld;
    logic                   r_s0_first;
    logic                   r_s0_close;

    logic                   r_e_vld;
    logic [VW-1:0]          r_e_p1;
    logic [VW-1:0]          r_e_p2;

    logic signed [CW-1:0]   w_x1, w_y1, w_x2, w_y2;
    logic signed [CW-1:0]   w_ylo, w_yhi, w_xhi;
    logic signed [DW-1:0]   w_dpx, w_dpy, w_dx, w_dy;
    logic signed [PW-1:0]   w_lhs, w_rhs;
    logic                   w_pass;

    logic                   r_m_vld;
    logic                   r_m_pass;
    logic                   r_m_vert;
    logic                   r_m_dypos;
    logic signed [PW-1:0]   r_m_lhs;
    logic signed [PW-1:0]   r_m_rhs;
    logic                   w_left;

    logic                   r_parity;
    logic                   r_out_vld;
    logic                   r_out_inside;

    // loads beyond the store are dropped
    assign w_wr_en = i_cmd.wr_en && (32'(i_vertex_index) < MAX_VERTICES);

    pip_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (AW'(i_vertex_index)),
        .i_wdata ({i_y_coord, i_x_coord}),
        .i_re    (i_cmd.rd_en),
        .i_raddr (i_rd_addr),
        .o_rdata (w_rdata)
    );

    // closing edge reuses vertex 0
    assign w_cur = r_s0_close ? r_v0 : w_rdata;

    assign w_x1 = $signed(r_e_p1[CW-1:0]);
    assign w_y1 = $signed(r_e_p1[VW-1:CW]);
    assign w_x2 = $signed(r_e_p2[CW-1:0]);
    assign w_y2 = $signed(r_e_p2[VW-1:CW]);

    assign w_ylo = (w_y1 < w_y2) ? w_y1 : w_y2;
    assign w_yhi = (w_y1 < w_y2) ? w_y2 : w_y1;
    assign w_xhi = (w_x1 < w_x2) ? w_x2 : w_x1;

    assign w_pass = (r_py > w_ylo) && (r_py <= w_yhi) && (r_px <= w_xhi) && (w_y1 != w_y2);

    assign w_dpx = $signed({r_px[CW-1], r_px}) - $signed({w_x1[CW-1], w_x1});
    assign w_dpy = $signed({r_py[CW-1], r_py}) - $signed({w_y1[CW-1], w_y1});
    assign w_dx  = $signed({w_x2[CW-1], w_x2}) - $signed({w_x1[CW-1], w_x1});
    assign w_dy  = $signed({w_y2[CW-1], w_y2}) - $signed({w_y1[CW-1], w_y1});

    assign w_lhs = w_dpx * w_dy;
    assign w_rhs = w_dpy * w_dx;

    assign w_left = r_m_vert || (r_m_dypos ? (r_m_lhs <= r_m_rhs) : (r_m_rhs <= r_m_lhs));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_e_vld   <= 1'b0;
            r_m_vld   <= 1'b0;
            r_parity  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s0_vld <= i_cmd.rd_en || i_cmd.close;
            r_e_vld  <= r_s0_vld && !r_s0_first;
            r_m_vld  <= r_e_vld;
            if (i_cmd.clear) begin
                r_parity <= 1'b0;
            end else if (r_m_vld && r_m_pass && w_left) begin
                r_parity <= !r_parity;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_first <= i_cmd.first;
        r_s0_close <= i_cmd.close;
        if (i_cmd.capture) begin
            r_px <= i_x_coord;
            r_py <= i_y_coord;
        end
        if (r_s0_vld) begin
            r_prev <= w_cur;
            if (r_s0_first) begin
                r_v0 <= w_rdata;
            end
        end
        r_e_p1    <= r_prev;
        r_e_p2    <= w_cur;
        r_m_pass  <= w_pass;
        r_m_vert  <= (w_x1 == w_x2);
        r_m_dypos <= !w_dy[DW-1];
        r_m_lhs   <= w_lhs;
        r_m_rhs   <= w_rhs;
        if (i_cmd.load_out) begin
            r_out_inside <= r_parity;
        end
    end

    assign o_sts.busy     = r_s0_vld || r_e_vld || r_m_vld;
    assign o_sts.out_full = r_out_vld;
    assign o_res_valid    = r_out_vld;
    assign o_inside_res   = r_out_inside;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the point-in-polygon test block with random stalls.
`timescale 1ns / 1ps

module tb;

    localparam int CW         = 16;
    localparam int NSLOTS     = 64;
    localparam int DRAIN      = 80;
    localparam int LIMIT      = 400000;
    localparam int PHASE_LEN  = 42;

    typedef enum {SCALE_FULL, SCALE_MID, SCALE_SMALL} t_coord_scale;

    typedef struct packed {
        logic                           mode;
        logic [pip_pkg::VIDX_WIDTH-1:0] vertex_index;
        logic signed [CW-1:0]           x_coord;
        logic signed [CW-1:0]           y_coord;
    } t_pt_beat;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [pip_pkg::VCOUNT_WIDTH-1:0] cfg_wdata;

    pip_pt_if #(.COORD_WIDTH(CW)) pt_if ();
    pip_res_if res_if ();

    point_in_polygon_test #(
        .MAX_VERTICES(NSLOTS),
        .COORD_WIDTH (CW)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_pt       (pt_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    always #10 clk = ~clk;

    // predictor state
    logic signed [CW-1:0]             poly_x [NSLOTS];
    logic signed [CW-1:0]             poly_y [NSLOTS];
    logic [pip_pkg::VCOUNT_WIDTH-1:0] poly_count;

    // stimulus-side view of the store
    logic signed [CW-1:0]    gen_x [NSLOTS];
    logic signed [CW-1:0]    gen_y [NSLOTS];
    bit                      gen_written [NSLOTS];
    int                      gen_n;

    t_pt_beat beat_q [$];
    logic     inside_q [$];
    t_pt_beat cur_beat;
    int       send_gap;
    int       recv_gap;
    bit       send_calm;
    bit       recv_calm;
    int       fails;
    int       cycles;

    function automatic int clamp_count(logic [pip_pkg::VCOUNT_WIDTH-1:0] v);
        if (v < pip_pkg::VCOUNT_MIN) return pip_pkg::VCOUNT_MIN;
        if (v > NSLOTS) return NSLOTS;
        return v;
    endfunction

    function automatic logic point_inside_poly(logic signed [CW-1:0] px,
                                               logic signed [CW-1:0] py);
        int     n;
        int     j;
        int     crossings;
        longint x1, y1, x2, y2, ylo, yhi, xhi, dy, lhs, rhs;
        bit     left;
        n = clamp_count(poly_count);
        crossings = 0;
        for (int i = 0; i < n; i++) begin
            j  = (i + 1) % n;
            x1 = poly_x[i];
            y1 = poly_y[i];
            x2 = poly_x[j];
            y2 = poly_y[j];
            ylo = (y1 < y2) ? y1 : y2;
            yhi = (y1 < y2) ? y2 : y1;
            xhi = (x1 < x2) ? x2 : x1;
            if (longint'(py) <= ylo || longint'(py) > yhi) continue;
            if (longint'(px) > xhi) continue;
            if (y1 == y2) continue;
            if (x1 == x2) begin
                crossings++;
                continue;
            end
            dy  = y2 - y1;
            lhs = (longint'(px) - x1) * dy;
            rhs = (longint'(py) - y1) * (x2 - x1);
            left = (dy > 0) ? (lhs <= rhs) : (rhs <= lhs);
            if (left) crossings++;
        end
        return crossings[0];
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(t_coord_scale scale);
        int t;
        case (scale)
            SCALE_SMALL: t = int'($urandom_range(0, 16)) - 8;
            SCALE_MID:   t = int'($urandom_range(0, 2000)) - 1000;
            default: begin
                if ($urandom_range(0, 9) == 0)
                    t = $urandom_range(0, 1) ? 32767 : -32768;
                else
                    t = int'($urandom_range(0, 65535));
            end
        endcase
        return t[CW-1:0];
    endfunction

    task automatic queue_beat(logic mode, logic [pip_pkg::VIDX_WIDTH-1:0] idx,
                              logic signed [CW-1:0] x, logic signed [CW-1:0] y);
        t_pt_beat b;
        b.mode = mode;
        b.vertex_index = idx;
        b.x_coord = x;
        b.y_coord = y;
        beat_q.push_back(b);
        if (mode == pip_pkg::MODE_LOAD) begin
            gen_x[idx] = x;
            gen_y[idx] = y;
            gen_written[idx] = 1'b1;
        end
    endtask

    task automatic write_vertex_count(logic [pip_pkg::VCOUNT_WIDTH-1:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        poly_count = v;
        gen_n = clamp_count(v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (beat_q.size() != 0 || pt_if.valid || inside_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic queue_random_point(t_coord_scale scale);
        int r;
        int a;
        int b;
        int dx;
        int dy;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        r  = $urandom_range(0, 99);
        a  = $urandom_range(0, gen_n - 1);
        b  = $urandom_range(0, gen_n - 1);
        dx = int'($urandom_range(0, 2)) - 1;
        dy = int'($urandom_range(0, 2)) - 1;
        if (r < 25) begin
            px = rand_coord(scale);
            py = rand_coord(scale);
        end else if (r < 60) begin
            px = gen_x[a] + dx[CW-1:0];
            py = gen_y[a] + dy[CW-1:0];
        end else begin
            px = gen_x[a] + dx[CW-1:0];
            py = gen_y[b];
        end
        queue_beat(pip_pkg::MODE_TEST, 6'($urandom_range(0, 63)), px, py);
    endtask

    task automatic run_phase(logic [pip_pkg::VCOUNT_WIDTH-1:0] cv, t_coord_scale scale,
                             int items);
        int r;
        write_vertex_count(cv);
        @(negedge clk);
        for (int i = 0; i < gen_n; i++)
            if (!gen_written[i])
                queue_beat(pip_pkg::MODE_LOAD, 6'(i), rand_coord(scale), rand_coord(scale));
        for (int k = 0; k < items; k++) begin
            r = $urandom_range(0, 99);
            if (r < 20)
                queue_beat(pip_pkg::MODE_LOAD, 6'($urandom_range(0, gen_n - 1)),
                           rand_coord(scale), rand_coord(scale));
            else if (r < 30)
                queue_beat(pip_pkg::MODE_LOAD, 6'($urandom_range(0, 63)),
                           rand_coord(scale), rand_coord(scale));
            else
                queue_random_point(scale);
        end
        wait_idle();
    endtask

    // input driver
    always @(posedge clk) begin : drv
        logic nv;
        if (!rst_n) begin
            pt_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            nv = pt_if.valid;
            if (pt_if.valid && pt_if.ready) begin
                if (cur_beat.mode == pip_pkg::MODE_LOAD) begin
                    poly_x[cur_beat.vertex_index] = cur_beat.x_coord;
                    poly_y[cur_beat.vertex_index] = cur_beat.y_coord;
                end else begin
                    inside_q.push_back(point_inside_poly(cur_beat.x_coord,
                                                         cur_beat.y_coord));
                end
                nv = 1'b0;
                if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
                send_gap = draw_gap(send_calm);
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (beat_q.size() != 0) begin
                    cur_beat = beat_q.pop_front();
                    nv = 1'b1;
                    pt_if.mode         <= cur_beat.mode;
                    pt_if.vertex_index <= cur_beat.vertex_index;
                    pt_if.x_coord      <= cur_beat.x_coord;
                    pt_if.y_coord      <= cur_beat.y_coord;
                end
            end
            pt_if.valid <= nv;
        end
    end

    // result monitor
    always @(posedge clk) begin : mon
        logic exp_inside;
        logic rdy;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (inside_q.size() == 0) begin
                    $error("inside_res: no beat expected, actual %0b", res_if.inside_res);
                    fails++;
                end else begin
                    exp_inside = inside_q.pop_front();
                    if (res_if.inside_res !== exp_inside) begin
                        $error("inside_res: expected %0b, actual %0b",
                               exp_inside, res_if.inside_res);
                        fails++;
                    end
                end
                if ($urandom_range(0, 19) == 0) recv_calm = ~recv_calm;
                recv_gap = draw_gap(recv_calm);
            end
            if (recv_gap > 0) begin
                recv_gap--;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            res_if.ready <= rdy;
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        pt_if.valid        = 1'b0;
        pt_if.mode         = pip_pkg::MODE_LOAD;
        pt_if.vertex_index = '0;
        pt_if.x_coord      = '0;
        pt_if.y_coord      = '0;
        res_if.ready       = 1'b0;
        poly_count         = pip_pkg::VCOUNT_RESET;
        gen_n              = clamp_count(pip_pkg::VCOUNT_RESET);
        fails              = 0;
        cycles             = 0;
        send_calm          = 1'b0;
        recv_calm          = 1'b0;
        for (int i = 0; i < NSLOTS; i++) begin
            gen_written[i] = 1'b0;
            poly_x[i] = '0;
            poly_y[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extreme triangle at the reset vertex count
        queue_beat(pip_pkg::MODE_LOAD, 6'd0, -16'sd32768, -16'sd32768);
        queue_beat(pip_pkg::MODE_LOAD, 6'd1, 16'sd32767, -16'sd32768);
        queue_beat(pip_pkg::MODE_LOAD, 6'd2, 16'sd0, 16'sd32767);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, 16'sd0);
        queue_beat(pip_pkg::MODE_TEST, 6'h3F, -16'sd32768, -16'sd32768);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd32767, 16'sd32767);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, 16'sd32767);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, -16'sd32768, 16'sd32767);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd32767, -16'sd32768);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, -16'sd32768);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, -16'sd32767);
        queue_beat(pip_pkg::MODE_LOAD, 6'h3F, 16'sd32767, 16'sd32767);
        // right triangle: vertical, slanted and horizontal edges
        queue_beat(pip_pkg::MODE_LOAD, 6'd0, 16'sd0, 16'sd0);
        queue_beat(pip_pkg::MODE_LOAD, 6'd1, 16'sd0, 16'sd100);
        queue_beat(pip_pkg::MODE_LOAD, 6'd2, 16'sd100, 16'sd0);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, 16'sd50);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, -16'sd1, 16'sd50);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd1, 16'sd50);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd50, 16'sd50);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd51, 16'sd50);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd50, 16'sd0);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, 16'sd100);
        queue_beat(pip_pkg::MODE_TEST, 6'd0, 16'sd0, 16'sd0);
        wait_idle();

        for (int p = 0; p < 12; p++) begin
            case (p)
                0:       run_phase(7'd3,   SCALE_SMALL, PHASE_LEN);
                1:       run_phase(7'd64,  SCALE_FULL,  PHASE_LEN);
                2:       run_phase(7'd0,   SCALE_SMALL, PHASE_LEN);
                3:       run_phase(7'd127, SCALE_MID,   PHASE_LEN);
                4:       run_phase(7'd65,  SCALE_SMALL, PHASE_LEN);
                5:       run_phase(7'd2,   SCALE_FULL,  PHASE_LEN);
                6:       run_phase(7'd1,   SCALE_MID,   PHASE_LEN);
                7:       run_phase(7'd4,   SCALE_SMALL, PHASE_LEN);
                11:      run_phase(7'($urandom_range(0, 127)), SCALE_FULL, PHASE_LEN);
                default: run_phase(7'($urandom_range(4, 63)), t_coord_scale'(p % 3),
                                   PHASE_LEN);
            endcase
        end

        if (fails == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pip_pkg.sv
rtl/pip_ifs.sv
rtl/pip_ram.sv
rtl/pip_ctrl.sv
rtl/pip_dp.sv
rtl/point_in_polygon_test.sv
tb/sv/tb.sv
